/* design/nsdf_pkg.sv */
// nsdf_pkg: shared constants and types of the spring-damper force block
// no dependencies; used by nsdf_iter, the top level and the testbench
package nsdf_pkg;

   localparam int DIM  = 3;
   localparam int AXES = 3;

   typedef enum logic {
      ITER_SQRT = 1'b0,
      ITER_DIV  = 1'b1
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_ctl_type;

endpackage

/* design/nonlinear_spring_damper_force_top.sv */
// nonlinear_spring_damper_force_top: cubic spring-damper force, sequenced datapath
// depends on nsdf_pkg and nsdf_iter (shared square root / divide unit)
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_delta_*, req_prior_delta_*
//   rsp      out        rsp_valid/rsp_stall  rsp_force_x/y/z
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// one request at a time; req_stall is high from acceptance until the result is taken
// the prior length is rebuilt from the prior deltas only when the stored length is zero; each
// square root and divide holds the shared unit, the five products run on the one 32x32
// multiplier, and a saturating axis skips its divide
// req_stall drops the cycle after the result is taken; the result holds while rsp_stall is high
// synchronous reset clears the sequencer, stored length and registers, not the datapath holds
module nonlinear_spring_damper_force_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_delta_x,
   input  logic signed [31:0] req_delta_y,
   input  logic signed [31:0] req_delta_z,
   input  logic signed [31:0] req_prior_delta_x,
   input  logic signed [31:0] req_prior_delta_y,
   input  logic signed [31:0] req_prior_delta_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import nsdf_pkg::*;

   localparam int          AXW     = $clog2(AXES + 1);
   localparam logic [50:0] CUBE_CAP = 51'd1 << 50;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_SUMC = 12'b000000000010,
      ST_RTC  = 12'b000000000100,
      ST_SUMP = 12'b000000001000,
      ST_RTP  = 12'b000000010000,
      ST_EVAL = 12'b000000100000,
      ST_PROD = 12'b000001000000,
      ST_FTOT = 12'b000010000000,
      ST_AXM  = 12'b000100000000,
      ST_AXC  = 12'b001000000000,
      ST_AXD  = 12'b010000000000,
      ST_OUT  = 12'b100000000000
   } state_type;

   typedef enum logic [2:0] {
      PR_LIN  = 3'd0,
      PR_SQ   = 3'd1,
      PR_CUB1 = 3'd2,
      PR_CUB2 = 3'd3,
      PR_DAMP = 3'd4
   } prod_type;

   typedef enum logic [1:0] {
      CSR_STIFF = 2'd0,
      CSR_CUBIC = 2'd1,
      CSR_REST  = 2'd2,
      CSR_DAMP  = 2'd3
   } csr_type;

   state_type          state_ff, state_in;
   prod_type           pr_ff, pr_in;
   logic [1:0]         ph_ff, ph_in;
   logic [AXW-1:0]     cnt_ff, cnt_in;
   logic [31:0]        stiff_ff, cubic_ff, damp_k_ff;
   logic [30:0]        rest_ff;
   logic signed [31:0] cur_ff [AXES];
   logic signed [31:0] pri_ff [AXES];
   logic signed [31:0] cur_in [AXES];
   logic signed [31:0] pri_in [AXES];
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        prod_ff;
   logic [31:0]        len_ff, len_in;
   logic [31:0]        prev_ff, prev_in;
   logic [31:0]        last_ff, last_in;
   logic [31:0]        emag_ff, emag_in, dmag_ff, dmag_in;
   logic               epos_ff, epos_in, eneg_ff, eneg_in;
   logic               dpos_ff, dpos_in, dneg_ff, dneg_in;
   logic [47:0]        lin_ff, lin_in, sq_ff, sq_in, damp_ff, damp_in;
   logic [50:0]        cub_ff, cub_in;
   logic [95:0]        full_ff, full_in;
   logic signed [31:0] ftot_ff, ftot_in;
   logic               sgn_ff, sgn_in;
   logic signed [31:0] force_ff [AXES];
   logic signed [31:0] force_in [AXES];
   logic               rsp_valid_ff, rsp_valid_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        pa;
   logic [31:0]        pb;
   iter_ctl_type       ictl;
   logic [63:0]        iopa;
   logic [31:0]        iopb;
   logic               idone;
   logic [31:0]        ires;
   logic [79:0]        shr;
   logic [50:0]        capped;
   logic signed [32:0] ediff, ddiff;
   logic [51:0]        amag;
   logic signed [53:0] fsum;
   logic               active;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   nsdf_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ictl),
      .opa    (iopa),
      .opb    (iopb),
      .done   (idone),
      .result (ires)
   );

   always_comb begin
      state_in     = state_ff;
      pr_in        = pr_ff;
      ph_in        = ph_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      pri_in       = pri_ff;
      acc_in       = acc_ff;
      len_in       = len_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      emag_in      = emag_ff;
      dmag_in      = dmag_ff;
      epos_in      = epos_ff;
      eneg_in      = eneg_ff;
      dpos_in      = dpos_ff;
      dneg_in      = dneg_ff;
      lin_in       = lin_ff;
      sq_in        = sq_ff;
      cub_in       = cub_ff;
      damp_in      = damp_ff;
      full_in      = full_ff;
      ftot_in      = ftot_ff;
      sgn_in       = sgn_ff;
      force_in     = force_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = '0;
      mul_b        = '0;
      ictl.start   = 1'b0;
      ictl.op      = ITER_SQRT;
      iopa         = acc_ff + prod_ff;
      iopb         = len_ff;
      ediff        = '0;
      ddiff        = '0;
      amag         = '0;
      fsum         = '0;
      active       = (32'(cnt_ff) < 32'(DIM)) && (len_ff != 32'd0);

      // operands of the product sequence
      case (pr_ff)
         PR_LIN:  begin pa = {32'd0, emag_ff};  pb = stiff_ff;  end
         PR_SQ:   begin pa = {32'd0, emag_ff};  pb = emag_ff;   end
         PR_CUB1: begin pa = {16'd0, sq_ff};    pb = cubic_ff;  end
         PR_CUB2: begin pa = {13'd0, cub_ff};   pb = emag_ff;   end
         PR_DAMP: begin pa = {32'd0, dmag_ff};  pb = damp_k_ff; end
         default: begin pa = '0;                pb = '0;        end
      endcase
      shr    = full_ff[95:16];
      capped = ((full_ff[95:64] != 32'd0) || (shr > 80'(CUBE_CAP))) ? CUBE_CAP : shr[50:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in[0] = req_delta_x;
               cur_in[1] = req_delta_y;
               cur_in[2] = req_delta_z;
               pri_in[0] = req_prior_delta_x;
               pri_in[1] = req_prior_delta_y;
               pri_in[2] = req_prior_delta_z;
               cnt_in    = '0;
               state_in  = ST_SUMC;
            end
         end
         ST_SUMC, ST_SUMP: begin
            if (32'(cnt_ff) < 32'(DIM)) begin
               mul_a = (state_ff == ST_SUMC) ? mag32(cur_ff[cnt_ff]) : mag32(pri_ff[cnt_ff]);
               mul_b = mul_a;
            end
            acc_in = (cnt_ff == '0) ? 64'd0 : acc_ff + prod_ff;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == 32'(DIM)) begin
               ictl.start = 1'b1;
               ictl.op    = ITER_SQRT;
               state_in   = (state_ff == ST_SUMC) ? ST_RTC : ST_RTP;
            end
         end
         ST_RTC: begin
            if (idone) begin
               len_in = ires;
               if (last_ff != 32'd0) begin
                  prev_in  = last_ff;
                  state_in = ST_EVAL;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_SUMP;
               end
            end
         end
         ST_RTP: begin
            if (idone) begin
               prev_in  = ires;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ediff    = $signed({1'b0, len_ff}) - $signed({2'b0, rest_ff});
            ddiff    = $signed({1'b0, len_ff}) - $signed({1'b0, prev_ff});
            emag_in  = ediff[32] ? 32'(-ediff) : ediff[31:0];
            dmag_in  = ddiff[32] ? 32'(-ddiff) : ddiff[31:0];
            epos_in  = !ediff[32] && (ediff != 33'sd0);
            eneg_in  = ediff[32];
            dpos_in  = !ddiff[32] && (ddiff != 33'sd0);
            dneg_in  = ddiff[32];
            pr_in    = PR_LIN;
            ph_in    = 2'd0;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            case (ph_ff)
               2'd0: begin
                  mul_a = pa[31:0];
                  mul_b = pb;
               end
               2'd1: begin
                  mul_a   = pa[63:32];
                  mul_b   = pb;
                  full_in = {32'd0, prod_ff};
               end
               2'd2: begin
                  full_in = full_ff + {prod_ff, 32'd0};
               end
               default: begin
                  case (pr_ff)
                     PR_LIN:  lin_in  = shr[47:0];
                     PR_SQ:   sq_in   = shr[47:0];
                     PR_CUB1: cub_in  = capped;
                     PR_CUB2: cub_in  = capped;
                     PR_DAMP: damp_in = shr[47:0];
                     default: ;
                  endcase
               end
            endcase
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd3) begin
               if (pr_ff == PR_DAMP) begin
                  state_in = ST_FTOT;
               end else begin
                  pr_in = prod_type'(pr_ff + 3'd1);
               end
            end
         end
         ST_FTOT: begin
            amag = 52'(lin_ff) + 52'(cub_ff);
            fsum = (epos_ff ? -$signed({2'b0, amag}) :
                    eneg_ff ?  $signed({2'b0, amag}) : 54'sd0)
                 + (dpos_ff ? -$signed({6'b0, damp_ff}) :
                    dneg_ff ?  $signed({6'b0, damp_ff}) : 54'sd0);
            if (fsum > 54'sd2147483647) begin
               ftot_in = 32'sh7fffffff;
            end else if (fsum < -54'sd2147483648) begin
               ftot_in = 32'sh80000000;
            end else begin
               ftot_in = fsum[31:0];
            end
            cnt_in   = '0;
            state_in = ST_AXM;
         end
         ST_AXM: begin
            if (32'(cnt_ff) == 32'(AXES)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else if (active) begin
               mul_a    = mag32(ftot_ff);
               mul_b    = mag32(cur_ff[cnt_ff]);
               state_in = ST_AXC;
            end else begin
               force_in[cnt_ff] = '0;
               cnt_in           = cnt_ff + 1'b1;
            end
         end
         ST_AXC: begin
            sgn_in = ftot_ff[31] ^ cur_ff[cnt_ff][31];
            if (prod_ff[63:32] >= len_ff) begin
               force_in[cnt_ff] = (ftot_ff[31] ^ cur_ff[cnt_ff][31]) ?
                                  32'sh80000000 : 32'sh7fffffff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_AXM;
            end else begin
               ictl.start = 1'b1;
               ictl.op    = ITER_DIV;
               iopa       = prod_ff;
               state_in   = ST_AXD;
            end
         end
         ST_AXD: begin
            if (idone) begin
               if (sgn_ff) begin
                  force_in[cnt_ff] = (ires > 32'h80000000) ? 32'sh80000000 : 32'(-ires);
               end else begin
                  force_in[cnt_ff] = (ires > 32'h7fffffff) ? 32'sh7fffffff : ires;
               end
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_AXM;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               last_in      = len_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pr_ff        <= PR_LIN;
         ph_ff        <= '0;
         cnt_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         stiff_ff     <= '0;
         cubic_ff     <= '0;
         rest_ff      <= '0;
         damp_k_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         pr_ff        <= pr_in;
         ph_ff        <= ph_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_type'(csr_index))
               CSR_STIFF: stiff_ff  <= csr_data;
               CSR_CUBIC: cubic_ff  <= csr_data;
               CSR_REST:  rest_ff   <= csr_data[30:0];
               CSR_DAMP:  damp_k_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= mul_a * mul_b;
      cur_ff   <= cur_in;
      pri_ff   <= pri_in;
      acc_ff   <= acc_in;
      len_ff   <= len_in;
      prev_ff  <= prev_in;
      emag_ff  <= emag_in;
      dmag_ff  <= dmag_in;
      epos_ff  <= epos_in;
      eneg_ff  <= eneg_in;
      dpos_ff  <= dpos_in;
      dneg_ff  <= dneg_in;
      lin_ff   <= lin_in;
      sq_ff    <= sq_in;
      cub_ff   <= cub_in;
      damp_ff  <= damp_in;
      full_ff  <= full_in;
      ftot_ff  <= ftot_in;
      sgn_ff   <= sgn_in;
      force_ff <= force_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_force_x = force_ff[0];
   assign rsp_force_y = force_ff[1];
   assign rsp_force_z = force_ff[2];
   assign csr_ready   = 1'b1;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_SUMC) else $error("request not started");
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !req_stall && !rsp_valid) else $error("no release");
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && len_ff == 32'd0 |-> rsp_force_x == 32'sd0 && rsp_force_y == 32'sd0
      && rsp_force_z == 32'sd0) else $error("nonzero force at zero length");
   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT) else $error("result outside output state");

endmodule

/* design/nsdf_iter.sv */
// nsdf_iter: shared bit-serial unit, 64-bit integer square root or 64/32 divide
// depends on nsdf_pkg; divide expects the upper dividend half below the divisor
module nsdf_iter (
   input  logic                  clock,
   input  logic                  reset,
   input  nsdf_pkg::iter_ctl_type ctl,
   input  logic [63:0]           opa,
   input  logic [31:0]           opb,
   output logic                  done,
   output logic [31:0]           result
);
   import nsdf_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   iter_op_type op_ff, op_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] src_ff, src_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] div_ff, div_in;
   logic [34:0] r2;
   logic [34:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      div_in  = div_ff;
      r2      = '0;
      trial   = '0;
      if (ctl.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = 5'd31;
         root_in = '0;
         div_in  = opb;
         if (ctl.op == ITER_SQRT) begin
            src_in = opa;
            rem_in = '0;
         end else begin
            src_in = {opa[31:0], 32'd0};
            rem_in = {3'd0, opa[63:32]};
         end
      end else if (busy_ff) begin
         if (op_ff == ITER_SQRT) begin
            r2     = {rem_ff[32:0], src_ff[63:62]};
            trial  = {1'b0, root_ff, 2'b01};
            src_in = {src_ff[61:0], 2'b00};
         end else begin
            r2     = {rem_ff[33:0], src_ff[63]};
            trial  = {3'd0, div_ff};
            src_in = {src_ff[62:0], 1'b0};
         end
         if (r2 >= trial) begin
            rem_in  = r2 - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = r2;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ITER_SQRT;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
   end

   assign done   = done_ff;
   assign result = root_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff) else $error("iter start while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff) else $error("iter done without run");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff && cnt_ff == 5'd31) else $error("iter start not taken");

endmodule

/* test/nonlinear_spring_damper_force_top_tb.sv */
// nonlinear_spring_damper_force_top_tb: randomized and directed check of the spring-damper force block
// depends on nsdf_pkg and nonlinear_spring_damper_force_top; predicts each force triple in fixed point
module nonlinear_spring_damper_force_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nsdf_pkg::*;

   typedef enum logic [1:0] {
      REG_STIFFNESS = 2'd0,
      REG_CUBIC     = 2'd1,
      REG_REST      = 2'd2,
      REG_DAMPING   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] dx, dy, dz, px, py, pz;
   } delta_type;

   typedef struct packed {
      logic signed [31:0] fx, fy, fz;
   } force_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0;
   logic req_stall, rsp_valid, csr_ready;
   logic req_taken = 0;
   logic signed [31:0] req_delta_x = 0, req_delta_y = 0, req_delta_z = 0;
   logic signed [31:0] req_prior_delta_x = 0, req_prior_delta_y = 0, req_prior_delta_z = 0;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic [1:0]  csr_index = REG_STIFFNESS;
   logic [31:0] csr_data = 0;

   nonlinear_spring_damper_force_top uut (.*);

   always #2 clock = ~clock;

   delta_type pending_deltas[$];
   force_type expected_forces[$];
   logic [63:0] k_lin, k_cub, l_rest, k_damp, stored_length;
   int send_idle_pct = 0, take_idle_pct = 0;
   int hold_off = 0;
   int mismatch_count = 0, force_count = 0, saturated_count = 0, zero_len_count = 0;

   task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                  input logic signed [31:0] want);
      $display("force %0d field %s got %0d expected %0d", force_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] span(input logic signed [31:0] a, b, c);
      logic [63:0] s, m;
      logic signed [31:0] v[3];
      s = 0;
      v[0] = a; v[1] = b; v[2] = c;
      for (int i = 0; i < DIM; i++) begin
         m = magnitude(64'(v[i]));
         s = s + m * m;
      end
      return root_floor(s);
   endfunction

   // a raw product beyond 64 bits caps outright
   function automatic logic [63:0] capped_product(input logic [63:0] a, b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      if (p[127:64] != 64'd0) return 64'd1 << 50;
      p = p >> 16;
      return p > (128'd1 << 50) ? 64'd1 << 50 : 64'(p);
   endfunction

   function automatic force_type spring_force(input delta_type d);
      logic [63:0] len, prev, emag, dmag, lin, cub, dmp;
      logic signed [63:0] e, dl, ftot;
      logic signed [127:0] q;
      logic signed [31:0] c[3];
      logic signed [31:0] f[3];
      prev = stored_length != 0 ? stored_length : span(d.px, d.py, d.pz);
      len = span(d.dx, d.dy, d.dz);
      e = $signed(len) - $signed(l_rest);
      dl = $signed(len) - $signed(prev);
      emag = magnitude(e);
      dmag = magnitude(dl);
      lin = (k_lin * emag) >> 16;
      cub = capped_product(capped_product(k_cub, (emag * emag) >> 16), emag);
      dmp = (k_damp * dmag) >> 16;
      ftot = 0;
      if (e > 0) ftot = ftot - $signed(lin + cub);
      else if (e < 0) ftot = ftot + $signed(lin + cub);
      if (dl > 0) ftot = ftot - $signed(dmp);
      else if (dl < 0) ftot = ftot + $signed(dmp);
      ftot = clamp32(ftot);
      c[0] = d.dx; c[1] = d.dy; c[2] = d.dz;
      for (int i = 0; i < 3; i++) begin
         f[i] = 0;
         if (i < DIM && len != 0) begin
            q = (128'(ftot) * 128'(c[i])) / $signed({64'd0, len});
            if (q > 128'sd2147483647 || q < -128'sd2147483648) saturated_count++;
            f[i] = q > 128'sd2147483647 ? 32'sh7fffffff :
                   q < -128'sd2147483648 ? 32'sh80000000 : 32'(q);
         end
      end
      if (len == 0) zero_len_count++;
      stored_length = len;
      return '{f[0], f[1], f[2]};
   endfunction

   // request acceptance
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            expected_forces.push_back(spring_force({req_delta_x, req_delta_y, req_delta_z,
               req_prior_delta_x, req_prior_delta_y, req_prior_delta_z}));
            void'(pending_deltas.pop_front());
         end
         if (req_taken || !req_valid) begin
            if (pending_deltas.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1;
               {req_delta_x, req_delta_y, req_delta_z, req_prior_delta_x,
                req_prior_delta_y, req_prior_delta_z} <= pending_deltas[0];
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // response stall
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= $urandom_range(99) < take_idle_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_forces.size() == 0) begin
            report_mismatch("unexpected", rsp_force_x, 32'sd0);
         end else begin
            force_type w;
            w = expected_forces.pop_front();
            if (rsp_force_x !== w.fx) report_mismatch("force_x", rsp_force_x, w.fx);
            if (rsp_force_y !== w.fy) report_mismatch("force_y", rsp_force_y, w.fy);
            if (rsp_force_z !== w.fz) report_mismatch("force_z", rsp_force_z, w.fz);
         end
         force_count++;
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_STIFFNESS: k_lin = 64'(value);
         REG_CUBIC:     k_cub = 64'(value);
         REG_REST:      l_rest = {33'd0, value[30:0]};
         REG_DAMPING:   k_damp = 64'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain;
      while (pending_deltas.size() > 0 || req_valid || expected_forces.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_coord(input int scale);
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3: return $urandom;
         default: return $signed(32'($urandom_range(2 ** scale))) * ($urandom_range(1) ? 1 : -1);
      endcase
   endfunction

   task automatic random_phase(input int count);
      int s;
      for (int i = 0; i < count; i++) begin
         s = $urandom_range(12, 22);
         pending_deltas.push_back({pick_coord(s), pick_coord(s), pick_coord(s),
                                   pick_coord(s), pick_coord(s), pick_coord(s)});
      end
   endtask

   initial begin
      k_lin = 0; k_cub = 0; l_rest = 0; k_damp = 0; stored_length = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_reg(REG_STIFFNESS, 32'h0001_0000);
      write_reg(REG_CUBIC, 32'h0000_1000);
      write_reg(REG_REST, 32'h0002_0000);
      write_reg(REG_DAMPING, 32'h0000_8000);
      pending_deltas.push_back('0);
      pending_deltas.push_back({32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
      pending_deltas.push_back({32'sh0003_0000, 32'sh0004_0000, 32'sd0, 96'd0});
      pending_deltas.push_back({{3{32'sh7fffffff}}, {3{32'sh80000000}}});
      pending_deltas.push_back({{3{32'sh80000000}}, {3{32'sh7fffffff}}});
      pending_deltas.push_back({32'sd1, 32'sd0, 32'sd0, 96'd0});
      pending_deltas.push_back({32'sh0002_0000, 64'd0, 32'sh0001_0000, 64'd0});
      pending_deltas.push_back('0);
      pending_deltas.push_back({96'd0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
      pending_deltas.push_back({32'shffff_0000, 32'sh0000_8000, 32'sh8000_0001, 96'd0});
      drain();
      send_idle_pct = 26; take_idle_pct = 84;
      hold_off = 300;
      random_phase(400);
      drain();
      write_reg(REG_STIFFNESS, 32'hffff_ffff);
      write_reg(REG_CUBIC, 32'hffff_ffff);
      write_reg(REG_REST, 32'h7fff_ffff);
      write_reg(REG_DAMPING, 32'hffff_ffff);
      send_idle_pct = 84; take_idle_pct = 26;
      random_phase(400);
      drain();
      write_reg(REG_STIFFNESS, 32'd0);
      write_reg(REG_CUBIC, 32'd0);
      write_reg(REG_REST, 32'd0);
      write_reg(REG_DAMPING, $urandom);
      send_idle_pct = 0; take_idle_pct = 0;
      random_phase(200);
      drain();
      write_reg(REG_STIFFNESS, $urandom);
      write_reg(REG_CUBIC, $urandom_range(255));
      write_reg(REG_REST, $urandom);
      random_phase(240);
      drain();
      $display("covered %0d force results, %0d saturated axes, %0d zero-length steps",
               force_count, saturated_count, zero_len_count);
      if (mismatch_count == 0 && expected_forces.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #8ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

/* sim.f */
design/nsdf_pkg.sv
design/nsdf_iter.sv
design/nonlinear_spring_damper_force_top.sv
test/nonlinear_spring_damper_force_top_tb.sv
